>>> hw/rtl/mec_pkg.sv
// Shared types and constants for the Mandelbrot escape colour unit.
// Used by the controller, the datapath and the top level; depends on nothing else.
package mec_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_EVAL,
        ST_UPDATE,
        ST_DONE
    } mec_state_t;

    // Limb pass of the multipliers: low by low, low by high, high by low, high by high
    typedef enum logic [1:0] {
        STEP_LL = 2'd0,
        STEP_LH = 2'd1,
        STEP_HL = 2'd2,
        STEP_HH = 2'd3
    } mec_step_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      idle;
        logic      load;
        logic      clear_acc;
        logic      mul_en;
        mec_step_t mul_step;
        logic      eval;
        logic      update;
        logic      finish;
    } mec_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_radius;
        logic below_limit;
        logic out_blocked;
    } mec_status_t;

    // Colour bases and register reset value
    localparam logic [7:0] BLUE_BASE        = 8'd255;
    localparam logic [7:0] GREEN_BASE       = 8'd125;
    localparam int         ITER_LIMIT_RESET = 255;

endpackage

>>> hw/rtl/mec_ctrl.sv
// Controller state machine of the Mandelbrot escape colour unit.
// Depends on mec_pkg for the state, command and status types.
module mec_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  mec_pkg::mec_status_t status,
    output mec_pkg::mec_cmd_t    cmd
);
    import mec_pkg::*;

    mec_state_t state_reg;
    mec_state_t state_next;
    mec_step_t  step_reg;
    mec_step_t  step_next;

    // State and limb step registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_LL;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = STEP_LL;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (step_reg == STEP_HH)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = mec_step_t'(step_reg + 2'd1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (status.in_radius && status.below_limit)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_MUL;
            end
            ST_DONE:
            begin
                if (!status.out_blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd           = '0;
        cmd.mul_step  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.idle      = 1'b1;
                cmd.load      = in_valid;
                cmd.clear_acc = in_valid;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.mul_en = 1'b0;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update    = 1'b1;
                cmd.clear_acc = 1'b1;
            end
            ST_DONE:
            begin
                cmd.finish = !status.out_blocked;
            end
            default:
            begin
                cmd.idle = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/mec_datapath.sv
// Datapath of the Mandelbrot escape colour unit: z registers, limb multipliers,
// escape test, iteration count, limit register and result register. Depends on mec_pkg.
module mec_datapath #(
    parameter int ITER_BITS = 12,
    parameter int FRAC_BITS = 28
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mec_pkg::mec_cmd_t     cmd,
    output mec_pkg::mec_status_t  status,
    input  logic                  cfg_wr_en,
    input  logic [ITER_BITS-1:0]  cfg_wr_data,
    input  logic signed [31:0]    c_re,
    input  logic signed [31:0]    c_im,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            blue,
    output logic [7:0]            green,
    output logic [7:0]            red,
    output logic [ITER_BITS-1:0]  iterations
);
    import mec_pkg::*;

    // z holds |c| < 2^31 plus a step of magnitude up to 4, with a sign bit to spare
    localparam int ZW = ((FRAC_BITS + 3 > 31) ? FRAC_BITS + 3 : 31) + 2;
    localparam int L  = (ZW + 1) / 2;
    localparam int MW = 2 * L;
    localparam int PW = 2 * MW;
    localparam int SW = PW + 1;

    logic signed [ZW-1:0] x_reg, y_reg, c_re_reg, c_im_reg;
    logic [ITER_BITS-1:0] n_reg, iter_limit_reg;

    logic [MW-1:0]        pp_xx_reg, pp_yy_reg, pp_xy_reg;
    logic [1:0]           pp_shift_reg;
    logic                 pp_valid_reg;
    logic [PW-1:0]        acc_xx_reg, acc_yy_reg, acc_xy_reg;
    logic signed [SW-1:0] diff_reg, xy_reg;

    logic                 out_valid_reg;
    logic [7:0]           blue_reg, green_reg;
    logic [ITER_BITS-1:0] iter_reg;

    logic [ZW-1:0]        abs_x, abs_y;
    logic [MW-1:0]        mag_x, mag_y;
    logic [L-1:0]         ax, bx, by;
    logic [L-1:0]         ay;
    logic [PW-1:0]        add_xx, add_yy, add_xy;
    logic [SW-1:0]        sum_sq, radius_lim;
    logic signed [SW-1:0] diff_next, xy_next;
    logic signed [SW-1:0] re_shift, im_shift;
    logic [15:0]          n_ext;
    logic [15:0]          n_half;
    logic                 at_limit;

    // Magnitudes of the z components split into two limbs
    assign abs_x = x_reg[ZW-1] ? -x_reg : x_reg;
    assign abs_y = y_reg[ZW-1] ? -y_reg : y_reg;
    assign mag_x = MW'(abs_x);
    assign mag_y = MW'(abs_y);

    // Limb selection for this pass: x*x, y*y and x*y
    assign ax = cmd.mul_step[1] ? mag_x[MW-1:L] : mag_x[L-1:0];
    assign bx = cmd.mul_step[0] ? mag_x[MW-1:L] : mag_x[L-1:0];
    assign ay = cmd.mul_step[1] ? mag_y[MW-1:L] : mag_y[L-1:0];
    assign by = cmd.mul_step[0] ? mag_y[MW-1:L] : mag_y[L-1:0];

    // Partial product registers, one pass per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_valid_reg <= 1'b0;
        end
        else
        begin
            pp_valid_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            pp_xx_reg    <= MW'(ax) * MW'(bx);
            pp_yy_reg    <= MW'(ay) * MW'(by);
            pp_xy_reg    <= MW'(ax) * MW'(by);
            pp_shift_reg <= {1'b0, cmd.mul_step[1]} + {1'b0, cmd.mul_step[0]};
        end
    end

    // Place each partial product at its limb weight
    always_comb
    begin
        case (pp_shift_reg)
            2'd0:
            begin
                add_xx = PW'(pp_xx_reg);
                add_yy = PW'(pp_yy_reg);
                add_xy = PW'(pp_xy_reg);
            end
            2'd1:
            begin
                add_xx = PW'(pp_xx_reg) << L;
                add_yy = PW'(pp_yy_reg) << L;
                add_xy = PW'(pp_xy_reg) << L;
            end
            default:
            begin
                add_xx = PW'(pp_xx_reg) << (2 * L);
                add_yy = PW'(pp_yy_reg) << (2 * L);
                add_xy = PW'(pp_xy_reg) << (2 * L);
            end
        endcase
    end

    // Product accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.clear_acc)
        begin
            acc_xx_reg <= '0;
            acc_yy_reg <= '0;
            acc_xy_reg <= '0;
        end
        else if (pp_valid_reg)
        begin
            acc_xx_reg <= acc_xx_reg + add_xx;
            acc_yy_reg <= acc_yy_reg + add_yy;
            acc_xy_reg <= acc_xy_reg + add_xy;
        end
    end

    // Escape test and exact x^2 - y^2 and signed x*y
    assign sum_sq     = {1'b0, acc_xx_reg} + {1'b0, acc_yy_reg};
    assign radius_lim = SW'(1) << (2 * FRAC_BITS + 2);
    assign diff_next  = signed'({1'b0, acc_xx_reg}) - signed'({1'b0, acc_yy_reg});
    assign xy_next    = (x_reg[ZW-1] ^ y_reg[ZW-1]) ? -signed'({1'b0, acc_xy_reg})
                                                    : signed'({1'b0, acc_xy_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            diff_reg <= diff_next;
            xy_reg   <= xy_next;
        end
    end

    // Rounding toward minus infinity is an arithmetic shift of the exact value
    assign re_shift = diff_reg >>> FRAC_BITS;
    assign im_shift = xy_reg >>> (FRAC_BITS - 1);

    // z, c and count registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            n_reg    <= '0;
            c_re_reg <= ZW'(c_re);
            c_im_reg <= ZW'(c_im);
        end
        else if (cmd.update)
        begin
            x_reg <= ZW'(re_shift) + c_re_reg;
            y_reg <= ZW'(im_shift) + c_im_reg;
            n_reg <= n_reg + ITER_BITS'(1);
        end
    end

    // Iteration limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_limit_reg <= ITER_BITS'(ITER_LIMIT_RESET);
        end
        else if (cfg_wr_en)
        begin
            iter_limit_reg <= cfg_wr_data;
        end
    end

    // Colour of the finished point
    assign n_ext    = 16'(n_reg);
    assign n_half   = n_ext >> 1;
    assign at_limit = (n_reg == iter_limit_reg);

    // Result register; a waiting result does not hold up the start of the next point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            blue_reg  <= at_limit ? 8'd0 : BLUE_BASE - n_ext[7:0];
            green_reg <= at_limit ? 8'd0 : GREEN_BASE - n_half[7:0];
            iter_reg  <= n_reg;
        end
    end

    assign status.in_radius   = (sum_sq <= radius_lim);
    assign status.below_limit = (n_reg < iter_limit_reg);
    assign status.out_blocked = out_valid_reg && out_stall;

    assign out_valid  = out_valid_reg;
    assign blue       = blue_reg;
    assign green      = green_reg;
    assign red        = 8'd0;
    assign iterations = iter_reg;

endmodule

>>> hw/rtl/mandelbrot_escape_colour_unit.sv
// Top level of the Mandelbrot escape colour unit.
// Instantiates mec_ctrl and mec_datapath; types come from mec_pkg.
//
// Takes one point c in signed fixed point (FRAC_BITS fraction bits) per input
// transaction and returns one result transaction with the escape count and the
// colour bytes. Each iteration forms x*x, y*y and x*y exactly with three limb
// multipliers of about half the z width, one limb pass per cycle over the passes
// LL, LH, HL and HH, followed by a drain, an evaluate and an update step. A
// finished result sits in an output register, so the next point is taken while it
// waits; should the next point finish before that result is taken, the block
// holds until it is. The iteration limit resets to 255 and may be written only
// while the block is idle.
module mandelbrot_escape_colour_unit #(
    parameter int ITER_BITS = 12,
    parameter int FRAC_BITS = 28
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [ITER_BITS-1:0] cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   c_re,
    input  logic signed [31:0]   c_im,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           blue,
    output logic [7:0]           green,
    output logic [7:0]           red,
    output logic [ITER_BITS-1:0] iterations
);
    import mec_pkg::*;

    mec_cmd_t    cmd;
    mec_status_t status;

    // Sequencer
    mec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and result storage
    mec_datapath #(
        .ITER_BITS (ITER_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .c_re        (c_re),
        .c_im        (c_im),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .iterations  (iterations)
    );

    // A new point is taken only while the sequencer is idle
    assign in_stall = !cmd.idle;

endmodule
